// File: src/u8d_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the UTF-8 stream decoder.
// No dependencies; used by the front, queue, back and top level.
package u8d_pkg;

  // byte classes decided by the front end
  localparam logic [1:0] CLS_ASCII = 2'd0;
  localparam logic [1:0] CLS_LEAD  = 2'd1;
  localparam logic [1:0] CLS_CONT  = 2'd2;
  localparam logic [1:0] CLS_BAD   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_SURROGATE = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  localparam int QUEUE_DEPTH = 4;

  // one classified byte as it travels from front to back
  typedef struct packed {
    logic [1:0] cls;
    logic [2:0] len;   // sequence length, lead bytes only
    logic [6:0] data;  // payload bits already masked
    logic       last;
  } entry_t;

endpackage

// File: src/u8d_front.sv
`timescale 1ns / 1ps
// Front end: accepts bytes and classifies them into queue entries.
// Depends on u8d_pkg.
module u8d_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              end_of_string,
  input  logic              queue_full,
  output logic              push,
  output u8d_pkg::entry_t   entry
);

  logic [2:0] lead_len;
  logic [6:0] lead_bits;

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    if (in_byte < 8'hE0) begin
      lead_len  = 3'd2;
      lead_bits = {2'b00, in_byte[4:0]};
    end else if (in_byte < 8'hF0) begin
      lead_len  = 3'd3;
      lead_bits = {3'b000, in_byte[3:0]};
    end else if (in_byte < 8'hF8) begin
      lead_len  = 3'd4;
      lead_bits = {4'b0000, in_byte[2:0]};
    end else if (in_byte < 8'hFC) begin
      lead_len  = 3'd5;
      lead_bits = {5'b00000, in_byte[1:0]};
    end else begin
      lead_len  = 3'd6;
      lead_bits = {6'b000000, in_byte[0]};
    end
  end

  always_comb begin
    entry.last = end_of_string;
    entry.len  = lead_len;
    if (!in_byte[7]) begin
      entry.cls  = u8d_pkg::CLS_ASCII;
      entry.data = in_byte[6:0];
    end else if (!in_byte[6]) begin
      entry.cls  = u8d_pkg::CLS_CONT;
      entry.data = {1'b0, in_byte[5:0]};
    end else if (in_byte <= 8'hFD) begin
      entry.cls  = u8d_pkg::CLS_LEAD;
      entry.data = lead_bits;
    end else begin
      entry.cls  = u8d_pkg::CLS_BAD;
      entry.data = 7'd0;
    end
  end

endmodule

// File: src/u8d_queue.sv
`timescale 1ns / 1ps
// Small FIFO of classified bytes between front and back.
// Depends on u8d_pkg.
module u8d_queue #(
  parameter int DEPTH = u8d_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u8d_pkg::entry_t wr_entry,
  input  logic            pop,
  output u8d_pkg::entry_t rd_entry,
  output logic            full,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u8d_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: src/u8d_back.sv
`timescale 1ns / 1ps
// Back end: sequence state, code point assembly and the output register.
// Depends on u8d_pkg.
module u8d_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  u8d_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [30:0]     code_point,
  output logic [1:0]      status,
  output logic [2:0]      seq_length,
  output logic            last_of_string
);

  logic [30:0] accumulator;
  logic [2:0]  remaining;
  logic [2:0]  seqlen;

  logic [30:0] accumulator_next;
  logic [2:0]  remaining_next;
  logic [2:0]  seqlen_next;
  logic        emit;
  logic [30:0] cp_next;
  logic [1:0]  st_next;
  logic [2:0]  len_next;

  logic [30:0] acc_shift;
  logic [2:0]  consumed;
  logic        surrogate;

  // advance only when the output slot is free or being taken
  assign pop = !empty && (!out_valid || out_ready);

  assign acc_shift = {accumulator[24:0], head.data[5:0]};
  assign consumed  = seqlen + 3'd1;
  assign surrogate = (acc_shift[30:16] == '0) && (acc_shift[15:11] == 5'b11011);

  always_comb begin
    accumulator_next = accumulator;
    remaining_next   = remaining;
    seqlen_next      = seqlen;
    emit             = 1'b0;
    cp_next          = '0;
    st_next          = u8d_pkg::ST_OK;
    len_next         = 3'd1;
    if (remaining == 3'd0) begin
      case (head.cls)
        u8d_pkg::CLS_ASCII: begin
          emit    = 1'b1;
          cp_next = {24'd0, head.data};
        end
        u8d_pkg::CLS_LEAD: begin
          if (head.last) begin
            emit    = 1'b1;
            st_next = u8d_pkg::ST_TRUNCATED;
          end else begin
            accumulator_next = {24'd0, head.data};
            remaining_next   = head.len - 3'd1;
            seqlen_next      = 3'd1;
          end
        end
        default: begin
          emit    = 1'b1;
          st_next = u8d_pkg::ST_MALFORMED;
        end
      endcase
    end else begin
      len_next = consumed;
      if (head.cls != u8d_pkg::CLS_CONT) begin
        // missing continuation: drop the sequence, consume this byte
        emit             = 1'b1;
        st_next          = u8d_pkg::ST_MALFORMED;
        accumulator_next = '0;
        remaining_next   = 3'd0;
        seqlen_next      = 3'd0;
      end else if (remaining == 3'd1) begin
        emit             = 1'b1;
        accumulator_next = '0;
        remaining_next   = 3'd0;
        seqlen_next      = 3'd0;
        if (surrogate) begin
          st_next = u8d_pkg::ST_SURROGATE;
        end else begin
          cp_next = acc_shift;
        end
      end else if (head.last) begin
        emit             = 1'b1;
        st_next          = u8d_pkg::ST_TRUNCATED;
        accumulator_next = '0;
        remaining_next   = 3'd0;
        seqlen_next      = 3'd0;
      end else begin
        accumulator_next = acc_shift;
        remaining_next   = remaining - 3'd1;
        seqlen_next      = consumed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      remaining   <= '0;
      seqlen      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        accumulator <= accumulator_next;
        remaining   <= remaining_next;
        seqlen      <= seqlen_next;
        out_valid   <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      code_point     <= cp_next;
      status         <= st_next;
      seq_length     <= len_next;
      last_of_string <= head.last;
    end
  end

  a_remaining_range: assert property (@(posedge clk) disable iff (rst)
    remaining <= 3'd5)
    else $error("continuation count out of range");

  a_length_budget: assert property (@(posedge clk) disable iff (rst)
    remaining != 3'd0 |-> (seqlen != 3'd0) && ({1'b0, seqlen} + {1'b0, remaining} <= 4'd6))
    else $error("open sequence longer than six bytes");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    remaining == 3'd0 |-> (seqlen == 3'd0) && (accumulator == '0))
    else $error("idle state holds stale sequence data");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != u8d_pkg::ST_OK) |-> code_point == '0)
    else $error("error result carries a code point");

endmodule

// File: src/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// UTF-8 stream decoder, one byte per clock while in_ready is high. An accepted byte
// is written to the queue; the back end pops it when the output slot is free or
// being taken and registers its result in the output register. A held output stops
// the back end, and the queue fills up to QUEUE_DEPTH bytes before in_ready drops.
// Reset (rst, synchronous) empties the queue, returns the decoder to idle
// and drops any pending result; no clearing pass is needed.
module utf8_stream_decoder #(
  parameter int QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] code_point,
  output logic [1:0]  status,
  output logic [2:0]  seq_length,
  output logic        last_of_string
);

  u8d_pkg::entry_t wr_entry;
  u8d_pkg::entry_t rd_entry;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  u8d_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .queue_full    (full),
    .push          (push),
    .entry         (wr_entry)
  );

  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .full     (full),
    .empty    (empty)
  );

  u8d_back u_back (
    .clk            (clk),
    .rst            (rst),
    .empty          (empty),
    .head           (rd_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .code_point     (code_point),
    .status         (status),
    .seq_length     (seq_length),
    .last_of_string (last_of_string)
  );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for utf8_stream_decoder: byte requests against a bit-level decoder
// model, with random gaps, stalls and long holds. Depends on u8d_pkg.
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int STREAM_BYTES   = 1200;
  localparam int HOLD_CYCLES    = 300;

  typedef struct packed {
    logic [30:0] cp;
    logic [1:0]  st;
    logic [2:0]  len;
    logic        last;
  } char_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        end_of_string;
  logic        out_valid;
  logic        out_ready;
  logic [30:0] code_point;
  logic [1:0]  status;
  logic [2:0]  seq_length;
  logic        last_of_string;

  // decoder state mirrored on the input side
  logic [30:0] dec_acc;
  logic [2:0]  dec_left;
  logic [2:0]  dec_len;

  char_t pending_chars[$];
  int    mismatches = 0;
  int    bytes_sent = 0;
  int    chars_checked = 0;
  int    status_count[4] = '{0, 0, 0, 0};
  bit    tx_burst = 1'b0;
  bit    rx_burst = 1'b0;
  int    rx_hold = 0;

  utf8_stream_decoder u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .end_of_string  (end_of_string),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .code_point     (code_point),
    .status         (status),
    .seq_length     (seq_length),
    .last_of_string (last_of_string)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the decoder by one byte; return 1 when the byte yields a result.
  function automatic bit decode_byte(input logic [7:0] b, input logic eos, output char_t r);
    logic [2:0] lead_len;
    logic [2:0] used;
    logic [30:0] value;
    r = '0;
    r.last = eos;
    if (dec_left == 3'd0) begin
      if (b < 8'h80) begin
        r.cp = 31'(b);
        r.st = u8d_pkg::ST_OK;
        r.len = 3'd1;
        return 1'b1;
      end
      if (b >= 8'hC0 && b <= 8'hFD) begin
        if (b < 8'hE0) lead_len = 3'd2;
        else if (b < 8'hF0) lead_len = 3'd3;
        else if (b < 8'hF8) lead_len = 3'd4;
        else if (b < 8'hFC) lead_len = 3'd5;
        else lead_len = 3'd6;
        if (eos) begin
          r.st = u8d_pkg::ST_TRUNCATED;
          r.len = 3'd1;
          return 1'b1;
        end
        dec_acc = 31'(b & (8'h1F >> (lead_len - 3'd2)));
        dec_left = lead_len - 3'd1;
        dec_len = 3'd1;
        return 1'b0;
      end
      r.st = u8d_pkg::ST_MALFORMED;
      r.len = 3'd1;
      return 1'b1;
    end
    used = dec_len + 3'd1;
    r.len = used;
    if (b[7:6] != 2'b10) begin
      {dec_acc, dec_left, dec_len} = '0;
      r.st = u8d_pkg::ST_MALFORMED;
      return 1'b1;
    end
    dec_acc = {dec_acc[24:0], b[5:0]};
    dec_left = dec_left - 3'd1;
    dec_len = used;
    if (dec_left == 3'd0) begin
      value = dec_acc;
      {dec_acc, dec_left, dec_len} = '0;
      if (value >= 31'h0000_D800 && value <= 31'h0000_DFFF)
        r.st = u8d_pkg::ST_SURROGATE;
      else r.cp = value;
      return 1'b1;
    end
    if (eos) begin
      {dec_acc, dec_left, dec_len} = '0;
      r.st = u8d_pkg::ST_TRUNCATED;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    $display("MISMATCH %s: expected 0x%0h got 0x%0h at %0t ns", what, want, got, $time);
    mismatches++;
  endtask

  // Offer one byte after a random gap; hold it until accepted, then predict.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    char_t ch;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (decode_byte(b, eos, ch)) pending_chars.push_back(ch);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  // Well-formed character with random payload, or a broken sequence, or noise.
  task automatic send_random_char();
    logic [7:0] seq [6];
    logic [7:0] nb;
    logic eos_end;
    int n, kind, cut, i;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: n = 1;
      4, 5:       n = 2;
      6:          n = 3;
      7:          n = 4;
      8:          n = 5;
      default:    n = 6;
    endcase
    for (i = 1; i < 6; i++) seq[i] = 8'h80 | 8'($urandom_range(0, 63));
    if (n == 1) seq[0] = 8'($urandom_range(0, 127));
    else seq[0] = (8'hFF << (8 - n)) | (8'($urandom) & (8'h1F >> (n - 2)));
    // steer some three-byte characters into the surrogate range
    if (n == 3 && $urandom_range(0, 4) == 0) begin
      seq[0] = 8'hED;
      seq[1] = 8'hA0 | 8'($urandom_range(0, 31));
    end
    eos_end = ($urandom_range(0, 5) == 0);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
    end else if (kind >= 75 && n > 1) begin
      cut = $urandom_range(1, n - 1);
      if (kind >= 83) begin
        do nb = 8'($urandom); while (nb[7:6] == 2'b10);
        seq[cut] = nb;
        for (i = 0; i <= cut; i++) send_byte(seq[i], (i == cut) && eos_end);
      end else begin
        for (i = 0; i < cut; i++) send_byte(seq[i], i == cut - 1);
      end
    end else begin
      for (i = 0; i < n; i++) send_byte(seq[i], (i == n - 1) && eos_end);
    end
  endtask

  task automatic test_valid_chars();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFD, 1'b0);
    repeat (5) send_byte(8'hBF, 1'b0);
    // lowest surrogate
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_malformed();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b1);
    // missing continuation on the last byte must win over truncation
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  task automatic test_truncation();
    send_byte(8'hE0, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  // Hold the output long enough that the block backs up into its input.
  task automatic test_output_stall();
    tx_burst = 1'b1;
    rx_hold = HOLD_CYCLES;
    repeat (60) send_byte(8'($urandom_range(0, 127)), $urandom_range(0, 3) == 0);
    tx_burst = 1'b0;
  endtask

  task automatic test_input_pause();
    repeat (30) send_random_char();
    in_valid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_random_stream();
    while (bytes_sent < STREAM_BYTES) begin
      if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
      send_random_char();
    end
    tx_burst = 1'b0;
  endtask

  initial begin : result_check
    char_t got;
    char_t want;
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 14);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = {code_point, status, seq_length, last_of_string};
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected result", 0, got);
      end else begin
        want = pending_chars.pop_front();
        if (got.cp !== want.cp) report_mismatch("code_point", want.cp, got.cp);
        if (got.st !== want.st) report_mismatch("status", want.st, got.st);
        if (got.len !== want.len) report_mismatch("seq_length", want.len, got.len);
        if (got.last !== want.last) report_mismatch("last_of_string", want.last, got.last);
        status_count[want.st]++;
        chars_checked++;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_byte <= 8'h00;
    end_of_string <= 1'b0;
    {dec_acc, dec_left, dec_len} = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_valid_chars();
    test_malformed();
    test_truncation();
    test_output_stall();
    test_input_pause();
    test_random_stream();
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d bytes, checked %0d results (ok %0d, malformed %0d,",
             bytes_sent, chars_checked, status_count[u8d_pkg::ST_OK],
             status_count[u8d_pkg::ST_MALFORMED]);
    $display("  surrogate %0d, truncated %0d); random gaps and stalls, full-rate bursts,",
             status_count[u8d_pkg::ST_SURROGATE], status_count[u8d_pkg::ST_TRUNCATED]);
    $display("  a %0d-cycle output hold and an input pause", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: utf8_stream_decoder.f
src/u8d_pkg.sv
src/u8d_front.sv
src/u8d_queue.sv
src/u8d_back.sv
src/utf8_stream_decoder.sv
dv/tb_top.sv
